### hw/rtl/mh2_pkg.sv
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared types and constants of the MurmurHash2 stream core.
// ----------------------------------------------------------------------------
package mh2_pkg;

   localparam logic [31:0] MIX_M   = 32'h5bd1e995;
   localparam int          MIX_R   = 24;
   localparam int          AVAL_R1 = 13;
   localparam int          AVAL_R2 = 15;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_EMPTY = 2'd0,
      OP_TAIL  = 2'd1,
      OP_FULL  = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic        first;
      logic        last;
      op_kind_type kind;
      logic [31:0] init;
      logic [31:0] word;
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_K2   = 2'd1,
      BK_HM   = 2'd2,
      BK_AV   = 2'd3
   } bk_state_type;

   typedef struct packed {
      bk_state_type state;
      logic         last;
   } bk_status_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
   } q_status_type;

endpackage

### hw/rtl/mh2_front.sv
// ----------------------------------------------------------------------------
// mh2_front
// Accepts key words, tracks message framing and classifies each word.
// ----------------------------------------------------------------------------
module mh2_front
   import mh2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_seed,
   input  logic [31:0] req_total_len,
   input  logic [31:0] req_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first,
   input  logic        req_last,
   output logic        push_valid,
   input  logic        push_ready,
   output op_type      push_op
);

   logic        in_message_ff;
   logic        in_message_in;
   logic        accept;
   logic [31:0] tail_mask;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   // Drop words that arrive outside a message.
   assign push_valid = req_valid && (req_first || in_message_ff);

   always_comb begin
      unique case (req_byte_count)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'h0000_0000;
      endcase
   end

   always_comb begin
      push_op.first = req_first;
      push_op.last  = req_last;
      push_op.init  = req_seed ^ req_total_len;
      if (req_byte_count >= 3'd4) begin
         push_op.kind = OP_FULL;
         push_op.word = req_word;
      end else if (req_byte_count == 3'd0) begin
         push_op.kind = OP_EMPTY;
         push_op.word = 32'h0;
      end else begin
         push_op.kind = OP_TAIL;
         push_op.word = req_word & tail_mask;
      end
   end

   always_comb begin
      in_message_in = in_message_ff;
      if (accept) begin
         in_message_in = (req_first || in_message_ff) && !req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

endmodule

### hw/rtl/mh2_queue.sv
// ----------------------------------------------------------------------------
// mh2_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module mh2_queue
   import mh2_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  op_type       wr_op,
   output logic         rd_valid,
   input  logic         rd_ready,
   output op_type       rd_op,
   output q_status_type status
);

   op_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_wr, do_rd;

   assign wr_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_op    = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;
   assign status.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_op;
      end
   end

endmodule

### hw/rtl/mh2_back.sv
// ----------------------------------------------------------------------------
// mh2_back
// Mixing sequencer around one shared multiply-by-M unit; holds the result.
// ----------------------------------------------------------------------------
module mh2_back
   import mh2_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          op_valid,
   output logic          op_ready,
   input  op_type        op,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_hash,
   output bk_status_type status
);

   bk_state_type state_ff, state_in;
   logic [31:0]  h_ff, h_in;
   logic [31:0]  k_ff, k_in;
   logic         last_ff, last_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_hash_ff, rsp_hash_in;
   logic [31:0]  h_sel;
   logic [31:0]  mul_a;
   logic [31:0]  mul_p;
   logic         rsp_free;

   assign h_sel    = op.first ? op.init : h_ff;
   assign mul_p    = mul_a * MIX_M;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign op_ready = (state_ff == BK_IDLE);

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      mul_a        = h_ff;
      unique case (state_ff)
         BK_IDLE: begin
            mul_a = (op.kind == OP_FULL) ? op.word : (h_sel ^ op.word);
            if (op_valid) begin
               last_in = op.last;
               unique case (op.kind)
                  OP_FULL: begin
                     h_in     = h_sel;
                     k_in     = mul_p;
                     state_in = BK_K2;
                  end
                  OP_TAIL: begin
                     h_in     = mul_p;
                     state_in = op.last ? BK_AV : BK_IDLE;
                  end
                  OP_EMPTY: begin
                     h_in     = h_sel;
                     state_in = op.last ? BK_AV : BK_IDLE;
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         BK_K2: begin
            mul_a    = k_ff ^ (k_ff >> MIX_R);
            k_in     = mul_p;
            state_in = BK_HM;
         end
         BK_HM: begin
            mul_a    = h_ff;
            h_in     = mul_p ^ k_ff;
            state_in = last_ff ? BK_AV : BK_IDLE;
         end
         BK_AV: begin
            mul_a = h_ff ^ (h_ff >> AVAL_R1);
            // Hold the finished hash until the output slot frees.
            if (rsp_free) begin
               h_in         = mul_p ^ (mul_p >> AVAL_R2);
               rsp_hash_in  = mul_p ^ (mul_p >> AVAL_R2);
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         h_ff         <= '0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         h_ff         <= h_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hash     = rsp_hash_ff;
   assign status.state = state_ff;
   assign status.last  = last_ff;

endmodule

### hw/rtl/murmur2_hash_stream_core.sv
// ----------------------------------------------------------------------------
// murmur2_hash_stream_core: streaming 32-bit MurmurHash2 over key words.
// A full word also steps the back sequencer through its K2 and HM states
// before the next word is taken; a tail or empty word is mixed in the idle
// state, as the shared multiply-by-M unit allows. The last word adds an
// avalanche step. Reset clears framing, queue, sequencer and output valid.
// ----------------------------------------------------------------------------
module murmur2_hash_stream_core
   import mh2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_seed,
   input  logic [31:0] req_total_len,
   input  logic [31:0] req_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash
);

   // Front to queue: classified operation, dropped if outside a message.
   logic          push_valid;
   logic          push_ready;
   op_type        push_op;

   // Queue to back sequencer.
   logic          pop_valid;
   logic          pop_ready;
   op_type        pop_op;

   q_status_type  q_status;
   bk_status_type bk_status;

   // Front: framing and byte-count classification. A transfer is taken
   // whenever the queue has room, dropped words included.
   mh2_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seed       (req_seed),
      .req_total_len  (req_total_len),
      .req_word       (req_word),
      .req_byte_count (req_byte_count),
      .req_first      (req_first),
      .req_last       (req_last),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_op        (push_op)
   );

   // Queue: decouple the front from the multi-cycle mixing.
   mh2_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_op    (push_op),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_op    (pop_op),
      .status   (q_status)
   );

   // Back: mix each word, run the avalanche on the last one and hold the
   // hash in the output register until its transfer.
   mh2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (pop_valid),
      .op_ready  (pop_ready),
      .op        (pop_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_hash  (rsp_hash),
      .status    (bk_status)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_k2_to_hm: assert property (@(posedge clock) disable iff (reset)
      bk_status.state == BK_K2 |=> bk_status.state == BK_HM)
      else $error("second key multiply not followed by hash multiply");

   a_av_on_last: assert property (@(posedge clock) disable iff (reset)
      bk_status.state == BK_AV |-> bk_status.last)
      else $error("avalanche entered for a word not marked last");

   a_rsp_from_av: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bk_status.state) == BK_AV)
      else $error("result raised without an avalanche step");
`endif

endmodule
